@@ hdl/apaf_pkg.sv @@
`default_nettype none
package apaf_pkg;

   typedef logic [5:0] six_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       own_report;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       sentence_end;
   } rsp_type;

   // one classified request: header flag, up to three six-bit units, trailer flag
   typedef struct packed {
      logic       hdr;
      logic       own;
      logic       last;
      logic [1:0] n_six;
      six_type    six0;
      six_type    six1;
      six_type    six2;
   } job_type;

   localparam logic [3:0] HDR_LAST = 4'd14;
   localparam logic [3:0] TRL_LAST = 4'd4;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   localparam logic [6:0] CH_BANG  = 7'h21;
   localparam logic [6:0] CH_COMMA = 7'h2c;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_ONE   = 7'h31;
   localparam logic [6:0] CH_TWO   = 7'h32;
   localparam logic [6:0] CH_STAR  = 7'h2a;
   localparam logic [6:0] CH_A     = 7'h41;
   localparam logic [6:0] CH_D     = 7'h44;
   localparam logic [6:0] CH_I     = 7'h49;
   localparam logic [6:0] CH_M     = 7'h4d;
   localparam logic [6:0] CH_O     = 7'h4f;
   localparam logic [6:0] CH_V     = 7'h56;

   function automatic logic [6:0] armor_char(input six_type v);
      logic [6:0] w;
      w = {1'b0, v};
      if (v < 6'd40) begin
         armor_char = w + 7'd48;
      end else begin
         armor_char = w + 7'd56;
      end
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      logic [6:0] w;
      w = {3'b000, n};
      if (n < 4'd10) begin
         hex_char = w + 7'd48;
      end else begin
         hex_char = w + 7'd55;
      end
   endfunction

   function automatic logic [6:0] hdr_char(input logic own, input logic [3:0] idx);
      case (idx)
         4'd0: begin
            hdr_char = CH_BANG;
         end
         4'd1, 4'd13: begin
            hdr_char = CH_A;
         end
         4'd2: begin
            hdr_char = CH_I;
         end
         4'd3: begin
            hdr_char = CH_V;
         end
         4'd4: begin
            hdr_char = CH_D;
         end
         4'd5: begin
            hdr_char = own ? CH_O : CH_M;
         end
         4'd7, 4'd9: begin
            hdr_char = CH_ONE;
         end
         4'd11: begin
            hdr_char = own ? CH_TWO : CH_ONE;
         end
         default: begin
            hdr_char = CH_COMMA;
         end
      endcase
   endfunction

endpackage
`default_nettype wire

@@ hdl/apaf_front.sv @@
`default_nettype none
module apaf_front
   import apaf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push_valid,
   output job_type      push_job
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       in_msg_ff, in_msg_in;
   logic       accept;
   logic [1:0] cur_phase;
   logic [1:0] new_phase;
   logic [7:0] b;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;
   assign b          = req_data.data_byte;

   always_comb begin
      cur_phase = in_msg_ff ? phase_ff : PHASE_0;
      push_job.hdr  = !in_msg_ff;
      push_job.own  = req_data.own_report;
      push_job.last = req_data.last_byte;
      push_job.six0 = b[7:2];
      push_job.six1 = '0;
      push_job.six2 = '0;
      push_job.n_six = 2'd1;
      new_phase = PHASE_1;
      case (cur_phase)
         PHASE_1: begin
            push_job.six0 = {held_ff[1:0], b[7:4]};
            new_phase = PHASE_2;
         end
         PHASE_2: begin
            push_job.six0 = {held_ff[3:0], b[7:6]};
            push_job.six1 = b[5:0];
            push_job.n_six = 2'd2;
            new_phase = PHASE_0;
         end
         default: begin
            push_job.six0 = b[7:2];
            new_phase = PHASE_1;
         end
      endcase
      // flush the partial group with zero bits
      if (req_data.last_byte) begin
         if (new_phase == PHASE_1) begin
            push_job.six1 = {b[1:0], 4'b0000};
            push_job.n_six = 2'd2;
         end else if (new_phase == PHASE_2) begin
            push_job.six1 = {b[3:0], 2'b00};
            push_job.n_six = 2'd2;
         end
      end
      // phase 2 with last never needs a flush unit, so six2 stays clear
      phase_in  = phase_ff;
      held_in   = held_ff;
      in_msg_in = in_msg_ff;
      if (accept) begin
         phase_in  = req_data.last_byte ? PHASE_0 : new_phase;
         held_in   = b;
         in_msg_in = !req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_0;
         held_ff   <= '0;
         in_msg_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         in_msg_ff <= in_msg_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/apaf_fifo.sv @@
`default_nettype none
module apaf_fifo
   import apaf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   job_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ hdl/apaf_back.sv @@
`default_nettype none
module apaf_back
   import apaf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [1:0] SEQ_NEW = 2'd0;
   localparam logic [1:0] SEQ_HDR = 2'd1;
   localparam logic [1:0] SEQ_SIX = 2'd2;
   localparam logic [1:0] SEQ_TRL = 2'd3;

   logic [1:0] seq_ff, seq_in;
   logic [3:0] idx_ff, idx_in;
   logic [6:0] xor_ff, xor_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       step;
   logic       done;
   logic       txt;
   logic       fin;
   logic [1:0] cur_seq;
   logic [3:0] cur_idx;
   logic [6:0] ch;
   six_type    six_sel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign job_pop   = step && done;

   always_comb begin
      step    = job_valid && (!rsp_valid_ff || !rsp_stall);
      cur_seq = (seq_ff == SEQ_NEW) ? (job.hdr ? SEQ_HDR : SEQ_SIX) : seq_ff;
      cur_idx = (seq_ff == SEQ_NEW) ? 4'd0 : idx_ff;
      case (cur_idx[1:0])
         2'd0: begin
            six_sel = job.six0;
         end
         2'd1: begin
            six_sel = job.six1;
         end
         default: begin
            six_sel = job.six2;
         end
      endcase
      ch     = '0;
      txt    = 1'b0;
      fin    = 1'b0;
      done   = 1'b0;
      seq_in = seq_ff;
      idx_in = idx_ff;
      case (cur_seq)
         SEQ_HDR: begin
            ch  = hdr_char(job.own, cur_idx);
            txt = (cur_idx != 4'd0);
            if (cur_idx == HDR_LAST) begin
               seq_in = SEQ_SIX;
               idx_in = '0;
            end else begin
               seq_in = SEQ_HDR;
               idx_in = cur_idx + 4'd1;
            end
         end
         SEQ_SIX: begin
            ch  = armor_char(six_sel);
            txt = 1'b1;
            if (cur_idx[1:0] == job.n_six - 2'd1) begin
               if (job.last) begin
                  seq_in = SEQ_TRL;
                  idx_in = '0;
               end else begin
                  seq_in = SEQ_NEW;
                  idx_in = '0;
                  done   = 1'b1;
               end
            end else begin
               seq_in = SEQ_SIX;
               idx_in = cur_idx + 4'd1;
            end
         end
         SEQ_TRL: begin
            case (cur_idx)
               4'd0: begin
                  ch = CH_COMMA;
               end
               4'd1: begin
                  ch = CH_ZERO;
               end
               4'd2: begin
                  ch = CH_STAR;
               end
               4'd3: begin
                  ch = hex_char({1'b0, xor_ff[6:4]});
               end
               default: begin
                  ch = hex_char(xor_ff[3:0]);
               end
            endcase
            txt = (cur_idx < 4'd2);
            if (cur_idx == TRL_LAST) begin
               fin    = 1'b1;
               seq_in = SEQ_NEW;
               idx_in = '0;
               done   = 1'b1;
            end else begin
               seq_in = SEQ_TRL;
               idx_in = cur_idx + 4'd1;
            end
         end
         default: begin
            ch = '0;
         end
      endcase
      if (!step) begin
         seq_in = seq_ff;
         idx_in = idx_ff;
      end

      xor_in = xor_ff;
      if (step) begin
         if (cur_seq == SEQ_HDR && cur_idx == 4'd0) begin
            xor_in = '0;
         end else if (txt) begin
            xor_in = xor_ff ^ ch;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_char     = ch;
         rsp_data_in.sentence_end = fin;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_NEW;
         idx_ff       <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         idx_ff       <= idx_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

@@ hdl/ais_payload_armor_framer_top.sv @@
// AIS payload armoring and NMEA framing: binary payload bytes go in, one
// single-sentence NMEA string comes out, one ASCII character per request on
// the rsp side and one character per clock at best. The first byte of a
// message adds '!' and the 14-character AIVDO or AIVDM header, each byte adds
// one or two armored characters, and the last byte adds the zero-padded
// flush character where needed plus ",0*" and two hex checksum digits;
// sentence_end marks the final digit. A typical stream of payload bytes runs
// at about 4 characters per 3 bytes, a rate set by the back-end character
// sequencer, which emits one character a cycle unless rsp_stall holds it.
// The front end classifies a byte in the cycle it is taken and parks it in a
// job queue of FIFO_DEPTH entries, so new bytes are taken while the header,
// trailer or a stalled output character is still being sent.
`default_nettype none
module ais_payload_armor_framer_top
   import apaf_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    queue_full;
   logic    push_valid;
   job_type push_job;
   logic    head_valid;
   job_type head_job;
   logic    job_pop;

   apaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   apaf_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   apaf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
